[rtl/pbs_pkg.sv]
// Package for the playback channel block sequencer.
// Holds the sizes, command and status codes and widths. No dependencies.
package pbs_pkg;

  localparam int unsigned NUM_CHANNELS = 4;
  localparam int unsigned BLOCK_SIZE   = 4096;

  localparam int unsigned CH_W   = 2;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned POS_W  = ADDR_W + 1;
  localparam int unsigned LEN_W  = 13;

  localparam logic [POS_W-1:0] BLOCK_SIZE_POS = POS_W'(BLOCK_SIZE);

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_READY = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_ISSUED     = 2'd0,
    STAT_NO_FREE    = 2'd1,
    STAT_NOT_ACTIVE = 2'd2
  } status_e;

  typedef logic [NUM_CHANNELS-1:0] ch_mask_t;

endpackage

[rtl/playback_channel_block_sequencer.sv]
// Top level of the playback channel block sequencer.
// Depends on pbs_pkg for sizes, command codes and status codes.
//
//   Channel   Direction  Handshake               Payload
//   request   in         start_i, busy_o         cmd_i, channel_i, start_offset_i,
//                                                region_length_i
//   result    out        done_o (one-cycle)      status_o, out_channel_o,
//                                                buffer_select_o, block_length_o,
//                                                final_blk_o
//
// A request transaction is taken at every clock edge at which start_i is high;
// busy_o stays low, so one request can enter in every cycle.
// Each request gives exactly one result transaction, passing first through the
// request register and then through the result register.
// The channel table is read from the request register and written with the result
// register, so a request sees everything that the request before it has changed.
// Reset clears the busy bits and the valid flags of both registers; the
// per-channel position, end and buffer entries are written on each issued block.
// The receiver cannot stall, so done_o is a strobe that holds for one cycle.
module playback_channel_block_sequencer
  import pbs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  output logic              busy_o,
  input  logic              cmd_i,
  input  logic [CH_W-1:0]   channel_i,
  input  logic [ADDR_W-1:0] start_offset_i,
  input  logic [ADDR_W-1:0] region_length_i,
  output logic              done_o,
  output logic [1:0]        status_o,
  output logic [CH_W-1:0]   out_channel_o,
  output logic              buffer_select_o,
  output logic [LEN_W-1:0]  block_length_o,
  output logic              final_blk_o
);

  // Request register.
  logic              req_vld_q;
  cmd_e              cmd_q;
  logic [CH_W-1:0]   ch_q;
  logic [ADDR_W-1:0] off_q;
  logic [ADDR_W-1:0] len_q;

  // Channel table. Busy bits are reset; the rest is written on each issued block.
  ch_mask_t          busy_q, busy_d;
  logic [POS_W-1:0]  pos_q [NUM_CHANNELS];
  logic [POS_W-1:0]  end_q [NUM_CHANNELS];
  logic              tog_q [NUM_CHANNELS];

  // Result register.
  logic              done_q;
  status_e           status_q, status_d;
  logic [CH_W-1:0]   och_q, och_d;
  logic              bsel_q, bsel_d;
  logic [LEN_W-1:0]  blen_q, blen_d;
  logic              last_q, last_d;

  // Working signals.
  logic              free_found;
  logic [CH_W-1:0]   free_idx;
  logic              is_start;
  logic              active;
  logic [CH_W-1:0]   sel_ch;
  logic [POS_W-1:0]  pos_cur;
  logic [POS_W-1:0]  end_cur;
  logic              tog_cur;
  logic [POS_W-1:0]  rem;
  logic              is_last;
  logic              do_issue;
  ch_mask_t          sel_mask;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_vld_q <= 1'b0;
    end else begin
      req_vld_q <= start_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cmd_q <= cmd_e'(cmd_i);
      ch_q  <= channel_i;
      off_q <= start_offset_i;
      len_q <= region_length_i;
    end
  end

  // Lowest free channel: scan from the top so that the lowest index wins.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (!busy_q[i]) begin
        free_found = 1'b1;
        free_idx   = CH_W'(i);
      end
    end
  end

  assign is_start = (cmd_q == CMD_START);
  assign sel_ch   = is_start ? free_idx : ch_q;

  // A ready request needs a channel that exists and is playing.
  always_comb begin
    if (is_start) begin
      active = free_found;
    end else begin
      active = (32'(ch_q) < NUM_CHANNELS) && busy_q[ch_q];
    end
  end

  // On a start the region is taken straight from the request, so the
  // remaining length is simply the region length.
  always_comb begin
    if (is_start) begin
      pos_cur = {1'b0, off_q};
      end_cur = {1'b0, off_q} + {1'b0, len_q};
      tog_cur = 1'b0;
      rem     = {1'b0, len_q};
    end else begin
      pos_cur = pos_q[ch_q];
      end_cur = end_q[ch_q];
      tog_cur = tog_q[ch_q];
      rem     = (end_q[ch_q] >= pos_q[ch_q]) ? (end_q[ch_q] - pos_q[ch_q]) : '0;
    end
  end

  assign is_last  = (rem <= BLOCK_SIZE_POS);
  assign do_issue = req_vld_q && active;

  always_comb begin
    sel_mask         = '0;
    sel_mask[sel_ch] = 1'b1;
  end

  // Busy bit is set by a start and cleared by the final block; an empty
  // region does both in one step and leaves the channel free.
  always_comb begin
    busy_d = busy_q;
    if (do_issue) begin
      if (is_start) begin
        busy_d = busy_d | sel_mask;
      end
      if (is_last) begin
        busy_d = busy_d & ~sel_mask;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= '0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_issue) begin
      pos_q[sel_ch] <= pos_cur + BLOCK_SIZE_POS;
      end_q[sel_ch] <= end_cur;
      tog_q[sel_ch] <= ~tog_cur;
    end
  end

  always_comb begin
    status_d = STAT_ISSUED;
    och_d    = sel_ch;
    bsel_d   = tog_cur;
    blen_d   = is_last ? rem[LEN_W-1:0] : BLOCK_SIZE_POS[LEN_W-1:0];
    last_d   = is_last;
    if (!active) begin
      bsel_d = 1'b0;
      blen_d = '0;
      last_d = 1'b0;
      if (is_start) begin
        status_d = STAT_NO_FREE;
        och_d    = '0;
      end else begin
        status_d = STAT_NOT_ACTIVE;
        och_d    = ch_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= req_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_vld_q) begin
      status_q <= status_d;
      och_q    <= och_d;
      bsel_q   <= bsel_d;
      blen_q   <= blen_d;
      last_q   <= last_d;
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign out_channel_o   = och_q;
  assign buffer_select_o = bsel_q;
  assign block_length_o  = blen_q;
  assign final_blk_o     = last_q;

`ifndef SYNTHESIS
  // Every accepted request produces a result after the request and result registers.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |=> ##1 done_o)
    else $error("request without result");

  // A final block leaves its channel free.
  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && final_blk_o) |-> !busy_q[out_channel_o])
    else $error("channel still busy after final block");

  // A refused request carries no block.
  a_refused_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != STAT_ISSUED)) |-> (block_length_o == '0 && !final_blk_o))
    else $error("refused request carries a block");

  // Blocks never exceed the block size.
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (block_length_o <= BLOCK_SIZE_POS[LEN_W-1:0]))
    else $error("block length above block size");
`endif

endmodule
